// File: hw/rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// shared types, constants and helpers of the periodic task table scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int MAX_OUT        = 16;

   localparam int FUNC_W   = 3;
   localparam int SLOTNO_W = 8;
   localparam int PERIOD_W = 16;
   localparam int PRIO_W   = 8;
   localparam int TAG_W    = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int TICK_W   = 16;
   localparam int USED_W   = 5;

   // parameter ram word: priority, period, countdown
   localparam int PRM_W = PRIO_W + 2 * PERIOD_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK   = 3'd0,
      FUNC_SPAWN  = 3'd1,
      FUNC_START  = 3'd2,
      FUNC_STOP   = 3'd3,
      FUNC_PERIOD = 3'd4,
      FUNC_DISP   = 3'd5,
      FUNC_STATUS = 3'd6,
      FUNC_CLEAR  = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_BADSLOT = 2'd2,
      ST_IDLE    = 2'd3
   } status_type;

   // countdown reload value for a period
   function automatic logic [PERIOD_W-1:0] rearm(input logic [PERIOD_W-1:0] p);
      return (p == '0) ? '0 : p - PERIOD_W'(1);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ptts_ram.sv
// ----------------------------------------------------------------------------
// ptts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/periodic_task_table_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler_core
// task slot table with tick countdowns and priority ordered dispatch
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one operation item (tick, spawn, start, stop, set period,
//   dispatch, status, clear); rsp_* returns result items, the final one of
//   an operation flagged by rsp_last_of_run. both channels are valid/ready.
//   req_ready is high only while the sequencer idles, one item at a time.
// operation flow:
//   stop, status, clear, zero-handler spawn and bad slot: the result item is
//     set directly from idle
//   start, set period: parameter ram read, then write, then the result item
//   spawn: first free slot search, one slot a cycle
//   tick: one countdown ram read-modify-write a cycle over every slot
//   dispatch: one selection pass over the shared priority compare per
//     picked slot, plus a final empty pass unless MAX_OUT are picked; then
//     each result item passes the emit read, load and wait states
// the parameter ram (priority, period, countdown) has one read port, which
// sets the one-slot-a-cycle pace of the tick and dispatch scans
// reset: slot flags, tick counter and used count clear at once; ram
// contents are only read for slots written since, so need no clearing
// stall: a result item holds on the rsp_ ports until taken; no new item
// is accepted meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_table_scheduler_core #(
   parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ptts_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ptts_pkg::SLOTNO_W-1:0]     req_slot_number,
   input  wire logic [ptts_pkg::PERIOD_W-1:0]     req_period_value,
   input  wire logic [ptts_pkg::PRIO_W-1:0]       req_priority_value,
   input  wire logic [ptts_pkg::TAG_W-1:0]        req_handler_tag,
   input  wire logic [ptts_pkg::TAG_W-1:0]        req_argument_tag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [ptts_pkg::INDEX_W-1:0]      rsp_slot_index,
   output logic      [ptts_pkg::TAG_W-1:0]        rsp_handler_out,
   output logic      [ptts_pkg::TAG_W-1:0]        rsp_argument_out,
   output logic                                   rsp_last_of_run,
   output logic      [ptts_pkg::STATUS_W-1:0]     rsp_status_code,
   output logic      [ptts_pkg::TICK_W-1:0]       rsp_tick_total,
   output logic      [ptts_pkg::USED_W-1:0]       rsp_used_count
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int PW = $clog2(ptts_pkg::MAX_OUT);
   localparam int TW = 2 * ptts_pkg::TAG_W;
   localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_TICK, S_SPAWN, S_RMW_RD, S_RMW_WR, S_PICK,
      S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT, S_RESP
   } state_type;

   state_type state_ff;

   // slot flags
   logic [SLOT_COUNT-1:0] used_ff, enabled_ff, ready_ff;
   logic [CW-1:0]         count_ff;
   logic [ptts_pkg::TICK_W-1:0] tick_ff;

   // latched item
   ptts_pkg::func_type           func_ff;
   logic [SW-1:0]                sn_ff;
   logic [ptts_pkg::PERIOD_W-1:0] per_ff;
   logic [ptts_pkg::PRIO_W-1:0]  pri_ff;
   logic [ptts_pkg::TAG_W-1:0]   htag_ff, atag_ff;

   // scan sequencer: issue index, then process it in the next cycle
   logic [SW-1:0] scan_ff, pidx_ff;
   logic          issue_done_ff, pv_ff;

   // dispatch selection
   logic          best_found_ff, best_pz_ff;
   logic [SW-1:0] best_idx_ff;
   logic [ptts_pkg::PRIO_W-1:0] best_pri_ff;
   logic [SW-1:0] picked_ff [ptts_pkg::MAX_OUT];
   logic [ptts_pkg::MAX_OUT-1:0] oneshot_ff;
   logic [PW:0]   pick_cnt_ff, pending_ff;
   logic [PW-1:0] emit_k_ff;

   // result registers
   logic                            rsp_valid_ff, rsp_last_ff;
   logic [ptts_pkg::INDEX_W-1:0]    rsp_slot_ff;
   logic [ptts_pkg::TAG_W-1:0]      rsp_handler_ff, rsp_argument_ff;
   ptts_pkg::status_type            rsp_status_ff;

   // rams
   logic                      prm_we;
   logic [SW-1:0]             prm_wa, prm_ra;
   logic [ptts_pkg::PRM_W-1:0] prm_wd, prm_rd;
   logic                      tag_we;
   logic [TW-1:0]             tag_wd, tag_rd;

   ptts_ram #(.WIDTH(ptts_pkg::PRM_W), .DEPTH(SLOT_COUNT)) u_prm_ram (
      .clock   (clock),
      .wr_en   (prm_we),
      .wr_addr (prm_wa),
      .wr_data (prm_wd),
      .rd_addr (prm_ra),
      .rd_data (prm_rd)
   );

   ptts_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (scan_ff),
      .wr_data (tag_wd),
      .rd_addr (picked_ff[emit_k_ff]),
      .rd_data (tag_rd)
   );

   // fields of the word just read
   logic [ptts_pkg::PRIO_W-1:0]   rd_pri;
   logic [ptts_pkg::PERIOD_W-1:0] rd_per, rd_cd;
   assign rd_pri = prm_rd[ptts_pkg::PRM_W-1 -: ptts_pkg::PRIO_W];
   assign rd_per = prm_rd[2*ptts_pkg::PERIOD_W-1 -: ptts_pkg::PERIOD_W];
   assign rd_cd  = prm_rd[ptts_pkg::PERIOD_W-1:0];

   // slot under processing is live (used and enabled)
   logic live_p;
   assign live_p = used_ff[pidx_ff] & enabled_ff[pidx_ff];

   // shared priority compare for dispatch
   logic take, scan_end, nb_found, nb_pz;
   logic [SW-1:0] nb_idx;
   logic [ptts_pkg::PRIO_W-1:0] nb_pri;
   assign take = pv_ff && live_p && ready_ff[pidx_ff]
                 && (!best_found_ff || (rd_pri < best_pri_ff));
   assign scan_end = pv_ff && (pidx_ff == LAST);
   assign nb_found = best_found_ff | take;
   assign nb_idx   = take ? pidx_ff : best_idx_ff;
   assign nb_pri   = take ? rd_pri : best_pri_ff;
   assign nb_pz    = take ? (rd_per == '0) : best_pz_ff;

   // request slot validity
   logic req_slot_ok;
   assign req_slot_ok = (32'(req_slot_number) < SLOT_COUNT)
                        && used_ff[SW'(req_slot_number)];

   // ram write and read control
   always_comb begin
      prm_we = 1'b0;
      prm_wa = scan_ff;
      prm_wd = {pri_ff, per_ff, ptts_pkg::rearm(per_ff)};
      tag_we = 1'b0;
      tag_wd = {htag_ff, atag_ff};
      prm_ra = (state_ff == S_IDLE || state_ff == S_RMW_RD) ? sn_ff : scan_ff;
      unique case (state_ff)
         S_SPAWN: begin
            prm_we = !used_ff[scan_ff];
            tag_we = !used_ff[scan_ff];
         end
         S_TICK: begin
            prm_we = pv_ff && live_p;
            prm_wa = pidx_ff;
            prm_wd = {rd_pri, rd_per,
                      (rd_cd == '0) ? ptts_pkg::rearm(rd_per) : rd_cd - 16'd1};
         end
         S_RMW_WR: begin
            prm_we = 1'b1;
            prm_wa = sn_ff;
            if (func_ff == ptts_pkg::FUNC_START) begin
               prm_wd = {rd_pri, rd_per, ptts_pkg::rearm(rd_per)};
            end else begin
               prm_wd = {rd_pri, per_ff, rd_cd};
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         enabled_ff    <= '0;
         ready_ff      <= '0;
         count_ff      <= '0;
         tick_ff       <= '0;
         pending_ff    <= '0;
         pick_cnt_ff   <= '0;
         emit_k_ff     <= '0;
         pv_ff         <= 1'b0;
         issue_done_ff <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // scan issue, shared by tick and dispatch passes
         if (state_ff == S_TICK || state_ff == S_PICK) begin
            if (!issue_done_ff) begin
               pidx_ff <= scan_ff;
               pv_ff   <= 1'b1;
               if (scan_ff == LAST) begin
                  issue_done_ff <= 1'b1;
               end else begin
                  scan_ff <= scan_ff + SW'(1);
               end
            end else begin
               pv_ff <= 1'b0;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff       <= ptts_pkg::func_type'(req_func);
                  sn_ff         <= SW'(req_slot_number);
                  per_ff        <= req_period_value;
                  pri_ff        <= req_priority_value;
                  htag_ff       <= req_handler_tag;
                  atag_ff       <= req_argument_tag;
                  scan_ff       <= '0;
                  issue_done_ff <= 1'b0;
                  pv_ff         <= 1'b0;
                  best_found_ff <= 1'b0;
                  pick_cnt_ff   <= '0;
                  pending_ff    <= '0;
                  emit_k_ff     <= '0;
                  // default single result
                  rsp_slot_ff     <= '0;
                  rsp_handler_ff  <= '0;
                  rsp_argument_ff <= '0;
                  rsp_last_ff     <= 1'b1;
                  rsp_status_ff   <= ptts_pkg::ST_OK;
                  unique case (ptts_pkg::func_type'(req_func))
                     ptts_pkg::FUNC_TICK: begin
                        tick_ff  <= tick_ff + 16'd1;
                        state_ff <= S_TICK;
                     end
                     ptts_pkg::FUNC_SPAWN: begin
                        if (req_handler_tag == '0) begin
                           rsp_status_ff <= ptts_pkg::ST_REFUSED;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_SPAWN;
                        end
                     end
                     ptts_pkg::FUNC_START, ptts_pkg::FUNC_PERIOD: begin
                        if (!req_slot_ok) begin
                           rsp_status_ff <= ptts_pkg::ST_BADSLOT;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_RMW_RD;
                        end
                     end
                     ptts_pkg::FUNC_STOP: begin
                        if (!req_slot_ok) begin
                           rsp_status_ff <= ptts_pkg::ST_BADSLOT;
                        end else begin
                           enabled_ff[SW'(req_slot_number)] <= 1'b0;
                           ready_ff[SW'(req_slot_number)]   <= 1'b0;
                           rsp_slot_ff <= 4'(req_slot_number);
                        end
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_RESP;
                     end
                     ptts_pkg::FUNC_DISP: begin
                        state_ff <= S_PICK;
                     end
                     ptts_pkg::FUNC_STATUS: begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_RESP;
                     end
                     ptts_pkg::FUNC_CLEAR: begin
                        used_ff      <= '0;
                        enabled_ff   <= '0;
                        ready_ff     <= '0;
                        count_ff     <= '0;
                        tick_ff      <= '0;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_RESP;
                     end
                  endcase
               end
            end

            S_TICK: begin
               if (pv_ff && live_p && (rd_cd == '0)) begin
                  ready_ff[pidx_ff] <= 1'b1;
               end
               if (scan_end) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end

            // first free slot, one flag a cycle
            S_SPAWN: begin
               if (!used_ff[scan_ff]) begin
                  used_ff[scan_ff]    <= 1'b1;
                  enabled_ff[scan_ff] <= 1'b1;
                  ready_ff[scan_ff]   <= 1'b0;
                  count_ff            <= count_ff + CW'(1);
                  rsp_slot_ff         <= 4'(scan_ff);
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_RESP;
               end else if (scan_ff == LAST) begin
                  rsp_status_ff <= ptts_pkg::ST_REFUSED;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  scan_ff <= scan_ff + SW'(1);
               end
            end

            S_RMW_RD: begin
               state_ff <= S_RMW_WR;
            end

            S_RMW_WR: begin
               if (func_ff == ptts_pkg::FUNC_START) begin
                  enabled_ff[sn_ff] <= 1'b1;
                  ready_ff[sn_ff]   <= 1'b0;
               end
               rsp_slot_ff  <= 4'(sn_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end

            // one selection pass per picked slot; a pass that picks none ends the picking
            S_PICK: begin
               if (pv_ff) begin
                  best_found_ff <= nb_found;
                  best_idx_ff   <= nb_idx;
                  best_pri_ff   <= nb_pri;
                  best_pz_ff    <= nb_pz;
               end
               if (scan_end) begin
                  scan_ff       <= '0;
                  issue_done_ff <= 1'b0;
                  pv_ff         <= 1'b0;
                  best_found_ff <= 1'b0;
                  if (nb_found) begin
                     ready_ff[nb_idx] <= 1'b0;
                     picked_ff[pick_cnt_ff[PW-1:0]]  <= nb_idx;
                     oneshot_ff[pick_cnt_ff[PW-1:0]] <= nb_pz;
                     pending_ff  <= pending_ff + (PW+1)'(nb_pz);
                     pick_cnt_ff <= pick_cnt_ff + (PW+1)'(1);
                     if (pick_cnt_ff == (PW+1)'(ptts_pkg::MAX_OUT - 1)) begin
                        state_ff <= S_EMIT_RD;
                     end
                  end else if (pick_cnt_ff == '0) begin
                     rsp_status_ff <= ptts_pkg::ST_IDLE;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_EMIT_RD;
                  end
               end
            end

            S_EMIT_RD: begin
               state_ff <= S_EMIT_LD;
            end

            S_EMIT_LD: begin
               rsp_slot_ff     <= 4'(picked_ff[emit_k_ff]);
               rsp_handler_ff  <= tag_rd[TW-1 -: ptts_pkg::TAG_W];
               rsp_argument_ff <= tag_rd[ptts_pkg::TAG_W-1:0];
               rsp_last_ff     <= ((PW+1)'(emit_k_ff) == pick_cnt_ff - (PW+1)'(1));
               rsp_status_ff   <= ptts_pkg::ST_OK;
               rsp_valid_ff    <= 1'b1;
               state_ff        <= S_EMIT_WAIT;
            end

            S_EMIT_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (oneshot_ff[emit_k_ff]) begin
                     used_ff[picked_ff[emit_k_ff]]    <= 1'b0;
                     enabled_ff[picked_ff[emit_k_ff]] <= 1'b0;
                     ready_ff[picked_ff[emit_k_ff]]   <= 1'b0;
                     count_ff   <= count_ff - CW'(1);
                     pending_ff <= pending_ff - (PW+1)'(1);
                  end
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     emit_k_ff <= emit_k_ff + PW'(1);
                     state_ff  <= S_EMIT_RD;
                  end
               end
            end

            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // used count after the whole operation: one-shot slots still to be freed
   // by this dispatch are already left out
   logic [CW-1:0] used_after;
   assign used_after = count_ff - CW'(pending_ff);

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_handler_out  = rsp_handler_ff;
   assign rsp_argument_out = rsp_argument_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_status_code  = rsp_status_ff;
   assign rsp_tick_total   = tick_ff;
   assign rsp_used_count   = (32'(used_after) > 31) ? 5'd31 : 5'(used_after);

`ifndef ASSERT_OFF
   a_rsp_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result item pending while idle");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   a_pending_le_count: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= 32'(count_ff))
      else $error("pending one-shot frees exceed used count");

   a_pick_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pick_cnt_ff) <= ptts_pkg::MAX_OUT)
      else $error("too many slots picked");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run |=> req_ready)
      else $error("block not idle after final result item");
`endif

endmodule

`default_nettype wire

// File: dv/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// watches both channels, predicts the result items of every accepted
// operation from its own copy of the slot table and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_checker
   import ptts_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [SLOTNO_W-1:0] req_slot_number,
   input  wire logic [PERIOD_W-1:0] req_period_value,
   input  wire logic [PRIO_W-1:0]   req_priority_value,
   input  wire logic [TAG_W-1:0]    req_handler_tag,
   input  wire logic [TAG_W-1:0]    req_argument_tag,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [INDEX_W-1:0]  rsp_slot_index,
   input  wire logic [TAG_W-1:0]    rsp_handler_out,
   input  wire logic [TAG_W-1:0]    rsp_argument_out,
   input  wire logic                rsp_last_of_run,
   input  wire logic [STATUS_W-1:0] rsp_status_code,
   input  wire logic [TICK_W-1:0]   rsp_tick_total,
   input  wire logic [USED_W-1:0]   rsp_used_count,
   output int                       fail_count,
   output int                       pending_count,
   output int                       result_total
);

   localparam int NS = SLOT_COUNT_DEF;

   typedef struct packed {
      logic [INDEX_W-1:0]  slot;
      logic [TAG_W-1:0]    handler;
      logic [TAG_W-1:0]    argument;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [TICK_W-1:0]   ticks;
      logic [USED_W-1:0]   used;
   } result_item;

   result_item expected_results[$];

   logic                used_q[NS], enabled_q[NS], ready_q[NS];
   logic [PERIOD_W-1:0] period_q[NS], countdown_q[NS];
   logic [PRIO_W-1:0]   prio_q[NS];
   logic [TAG_W-1:0]    handler_q[NS], argument_q[NS];
   logic [TICK_W-1:0]   tick_q;

   function automatic logic [PERIOD_W-1:0] reload(logic [PERIOD_W-1:0] p);
      return (p == 0) ? '0 : p - 1'b1;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < NS; i++) begin
         used_q[i] = 0; enabled_q[i] = 0; ready_q[i] = 0;
         period_q[i] = 0; countdown_q[i] = 0; prio_q[i] = 0;
         handler_q[i] = 0; argument_q[i] = 0;
      end
      tick_q = 0;
   endtask

   task automatic predict_operation(logic [FUNC_W-1:0] fn, logic [SLOTNO_W-1:0] sn,
                                    logic [PERIOD_W-1:0] per, logic [PRIO_W-1:0] pri,
                                    logic [TAG_W-1:0] ht, logic [TAG_W-1:0] at);
      result_item r[$];
      result_item one;
      int got, best, cnt, uc;
      int picked[$];
      logic ok;
      one = '0;
      one.last = 1;
      ok = (sn < NS) && used_q[sn[3:0]];
      case (func_type'(fn))
         FUNC_TICK: begin
            tick_q++;
            for (int i = 0; i < NS; i++)
               if (used_q[i] && enabled_q[i]) begin
                  if (countdown_q[i] == 0) begin
                     ready_q[i] = 1;
                     if (period_q[i] != 0) countdown_q[i] = reload(period_q[i]);
                  end else countdown_q[i]--;
               end
            r.push_back(one);
         end
         FUNC_SPAWN: begin
            got = -1;
            if (ht != 0)
               for (int i = 0; i < NS; i++)
                  if (!used_q[i] && got < 0) got = i;
            if (got < 0) one.status = ST_REFUSED;
            else begin
               handler_q[got] = ht; argument_q[got] = at; period_q[got] = per;
               countdown_q[got] = reload(per); prio_q[got] = pri;
               used_q[got] = 1; enabled_q[got] = 1; ready_q[got] = 0;
               one.slot = INDEX_W'(got);
            end
            r.push_back(one);
         end
         FUNC_START, FUNC_STOP, FUNC_PERIOD: begin
            if (!ok) one.status = ST_BADSLOT;
            else begin
               one.slot = sn[3:0];
               if (fn == FUNC_START) begin
                  countdown_q[sn] = reload(period_q[sn]);
                  enabled_q[sn] = 1; ready_q[sn] = 0;
               end else if (fn == FUNC_STOP) begin
                  enabled_q[sn] = 0; ready_q[sn] = 0;
               end else period_q[sn] = per;
            end
            r.push_back(one);
         end
         FUNC_DISP: begin
            cnt = 0;
            while (cnt < MAX_OUT) begin
               best = -1;
               for (int i = 0; i < NS; i++)
                  if (used_q[i] && enabled_q[i] && ready_q[i] &&
                      (best < 0 || prio_q[i] < prio_q[best])) best = i;
               if (best < 0) break;
               ready_q[best] = 0;
               picked.push_back(best);
               cnt++;
            end
            if (cnt == 0) begin
               one.status = ST_IDLE;
               r.push_back(one);
            end
            foreach (picked[k]) begin
               one = '0;
               one.slot = INDEX_W'(picked[k]);
               one.handler = handler_q[picked[k]];
               one.argument = argument_q[picked[k]];
               one.last = (k == cnt - 1);
               r.push_back(one);
               if (period_q[picked[k]] == 0) begin
                  used_q[picked[k]] = 0; enabled_q[picked[k]] = 0;
                  ready_q[picked[k]] = 0; handler_q[picked[k]] = 0;
               end
            end
         end
         FUNC_STATUS: r.push_back(one);
         default: begin
            clear_table();
            r.push_back(one);
         end
      endcase
      uc = 0;
      for (int i = 0; i < NS; i++) uc += used_q[i];
      if (uc > 31) uc = 31;
      foreach (r[k]) begin
         r[k].ticks = tick_q;
         r[k].used = USED_W'(uc);
         expected_results.push_back(r[k]);
      end
   endtask

   always @(posedge clock) begin
      result_item got_item, want;
      if (reset) begin
         clear_table();
         expected_results.delete();
         fail_count = 0;
         result_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_item = '{rsp_slot_index, rsp_handler_out, rsp_argument_out,
                         rsp_last_of_run, rsp_status_code, rsp_tick_total,
                         rsp_used_count};
            result_total++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, got_item);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got_item.slot !== want.slot || got_item.handler !== want.handler ||
                   got_item.argument !== want.argument || got_item.last !== want.last ||
                   got_item.status !== want.status || got_item.ticks !== want.ticks ||
                   got_item.used !== want.used) begin
                  $display("%0t: result mismatch expected slot %0d h %h a %h last %b st %0d tk %0d uc %0d",
                           $time, want.slot, want.handler, want.argument, want.last,
                           want.status, want.ticks, want.used);
                  $display("%0t:                  actual slot %0d h %h a %h last %b st %0d tk %0d uc %0d",
                           $time, got_item.slot, got_item.handler, got_item.argument,
                           got_item.last, got_item.status, got_item.ticks, got_item.used);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_operation(req_func, req_slot_number, req_period_value,
                              req_priority_value, req_handler_tag, req_argument_tag);
      end
      pending_count = expected_results.size();
   end

endmodule

// File: dv/tb_periodic_task_table_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_table_scheduler_core
// drives directed and random scheduler operations under varying back
// pressure; the checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_task_table_scheduler_core;
   import ptts_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func = FUNC_STATUS;
   logic [SLOTNO_W-1:0] req_slot_number = 0;
   logic [PERIOD_W-1:0] req_period_value = 0;
   logic [PRIO_W-1:0]   req_priority_value = 0;
   logic [TAG_W-1:0]    req_handler_tag = 0;
   logic [TAG_W-1:0]    req_argument_tag = 0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [INDEX_W-1:0]  rsp_slot_index;
   logic [TAG_W-1:0]    rsp_handler_out, rsp_argument_out;
   logic                rsp_last_of_run;
   logic [STATUS_W-1:0] rsp_status_code;
   logic [TICK_W-1:0]   rsp_tick_total;
   logic [USED_W-1:0]   rsp_used_count;

   int fail_count, pending_count, result_total;
   int send_idle_pct = 0;     // chance per cycle that the sender holds back
   int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
   bit recv_hold = 0;         // long receiver hold-off, timed below
   int items_sent = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   periodic_task_table_scheduler_core DUT (.*);

   ptts_checker u_checker (.*);

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one item: random gap first, then hold valid until accepted
   // returns just after the accepting edge; valid drops at the next falling
   // edge unless another item follows at once
   task automatic send_op(logic [FUNC_W-1:0] fn, logic [SLOTNO_W-1:0] sn,
                          logic [PERIOD_W-1:0] per, logic [PRIO_W-1:0] pri,
                          logic [TAG_W-1:0] ht, logic [TAG_W-1:0] at);
      bit accepted;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_func <= fn; req_slot_number <= sn; req_period_value <= per;
      req_priority_value <= pri; req_handler_tag <= ht; req_argument_tag <= at;
      accepted = 0;
      while (!accepted) begin
         // ready is stable through the low phase
         accepted = req_ready;
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // mostly small periods so slots fire often; sometimes any period
   task automatic random_op();
      int pick;
      logic [PERIOD_W-1:0] per;
      logic [SLOTNO_W-1:0] sn;
      pick = $urandom_range(99);
      per = ($urandom_range(9) == 0) ? PERIOD_W'($urandom) : PERIOD_W'($urandom_range(4));
      sn = ($urandom_range(7) == 0) ? SLOTNO_W'($urandom) : SLOTNO_W'($urandom_range(15));
      if (pick < 35)      send_op(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 55) send_op(FUNC_SPAWN, $urandom, per, $urandom,
                                  ($urandom_range(15) == 0) ? 0 : $urandom, $urandom);
      else if (pick < 62) send_op(FUNC_START, sn, per, $urandom, $urandom, $urandom);
      else if (pick < 68) send_op(FUNC_STOP, sn, per, $urandom, $urandom, $urandom);
      else if (pick < 74) send_op(FUNC_PERIOD, sn, per, $urandom, $urandom, $urandom);
      else if (pick < 92) send_op(FUNC_DISP, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 98) send_op(FUNC_STATUS, $urandom, $urandom, $urandom, $urandom, $urandom);
      else                send_op(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty table cases, bad slots, refused spawn
      send_op(FUNC_DISP, 0, 0, 0, 0, 0);
      send_op(FUNC_START, 8'hff, 0, 0, 0, 0);
      send_op(FUNC_STOP, 3, 0, 0, 0, 0);
      send_op(FUNC_PERIOD, 16, 16'hffff, 0, 0, 0);
      send_op(FUNC_SPAWN, 0, 5, 1, 0, 32'hffff_ffff);
      // fill the table: one-shots, period one, max period, priority extremes
      for (int i = 0; i < 16; i++)
         send_op(FUNC_SPAWN, 0, (i % 4 == 0) ? 0 : (i == 15 ? 16'hffff : 1),
                 (i == 3) ? 255 : (i % 3 == 0 ? 0 : 8'd200), 32'hffff_ffff - i,
                 (i == 1) ? 0 : 32'hffff_ffff);
      send_op(FUNC_SPAWN, 0, 1, 1, 32'h1, 32'h2);   // table full
      send_op(FUNC_TICK, 0, 0, 0, 0, 0);
      send_op(FUNC_TICK, 0, 0, 0, 0, 0);
      send_op(FUNC_DISP, 0, 0, 0, 0, 0);             // fifteen-slot run, slot 15 not yet due
      send_op(FUNC_STOP, 1, 0, 0, 0, 0);
      send_op(FUNC_PERIOD, 2, 0, 0, 0, 0);
      send_op(FUNC_START, 2, 0, 0, 0, 0);
      send_op(FUNC_STATUS, 0, 0, 0, 0, 0);
      send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 73) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 73) : 0;
         repeat (80) random_op();
         drain();
      end

      // long receiver hold-off while items keep arriving
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            recv_hold = 1;
            repeat (400) @(negedge clock);
            recv_hold = 0;
         end
         repeat (30) random_op();
      join
      drain();

      $display("sent %0d operation items, checked %0d result items", items_sent, result_total);
      $display("covered full table, refused spawns, bad slots, one-shots and stalls");
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ram.sv
hw/rtl/periodic_task_table_scheduler_core.sv
dv/ptts_checker.sv
dv/tb_periodic_task_table_scheduler_core.sv
